// ===== sv/lbsp_pkg.sv =====
`default_nettype none
package lbsp_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SKIN = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [7:0]         load_slot;
    logic [3:0]         element_slot;
    logic signed [31:0] load_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [27:0]        bone_indices;
    logic signed [31:0] weight_first;
    logic signed [31:0] weight_second;
    logic signed [31:0] weight_third;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
  } out_t;

endpackage
`default_nettype wire

// ===== sv/lbsp_in_if.sv =====
`default_nettype none
interface lbsp_in_if;
  logic          valid;
  logic          ready;
  lbsp_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/lbsp_out_if.sv =====
`default_nettype none
interface lbsp_out_if;
  logic           valid;
  logic           ready;
  lbsp_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/linear_blend_skinning_point.sv =====
`default_nettype none
// Four-bone linear blend skinning of one point, signed fixed point.
//
// Channels: item (sink) carries load and skin items; result (source) carries
// one saturated (x,y,z,w) per skin item. A transfer happens when valid and
// ready are both high at a rising clock edge.
// Load items with load_slot up to NUM_BONES write one matrix element in the
// cycle of their transfer and give no result; item.ready stays high, so loads
// stream one per cycle while no skin item is in progress. Skin items run on
// one shared 32x32 multiplier with a single read port into the matrix RAM:
// 64 blend products (B_RD, B_MUL, B_ACC), one point-term product per blended
// element (V_MUL, V_ACC) and 16 world products (W_RD, W_MUL, W_ACC). item.ready
// is low from the transfer until the result register is loaded.
// The result register frees the datapath: a new item is taken while an older
// result waits. A skin item that finishes while result is stalled holds in
// its final state until the register empties.
// Reset (rst, synchronous) clears control state only; the matrix RAM holds
// whatever it held and must be loaded before use.
module linear_blend_skinning_point #(
  parameter int NUM_BONES = 128,
  parameter int FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  lbsp_in_if.sink    item,
  lbsp_out_if.source result
);
  localparam int DEPTH = (NUM_BONES + 1) * 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = AW - 4;
  localparam logic [8:0] NB9 = 9'(NUM_BONES);
  localparam logic [SW-1:0] WORLD_SLOT = SW'(NUM_BONES);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] MAX66 = 66'sd2147483647;
  localparam logic signed [65:0] MIN66 = -66'sd2147483648;

  typedef enum logic [3:0] {
    IDLE, B_RD, B_MUL, B_ACC, V_MUL, V_ACC, W_RD, W_MUL, W_ACC, OUT
  } state_t;

  // floor(a / 2^FRAC_BITS), saturated to 32 bits
  function automatic logic signed [31:0] sat_shift(input logic signed [65:0] a);
    logic signed [65:0] s;
    s = a >>> FRAC_BITS;
    if (s > MAX66) return 32'sh7fffffff;
    if (s < MIN66) return -32'sh80000000;
    return s[31:0];
  endfunction

  state_t state;
  logic [1:0] i, j, k;
  logic signed [31:0] wgt [4];
  logic signed [31:0] vec [4];
  logic signed [31:0] mid [4];
  logic signed [31:0] res [4];
  logic [SW-1:0] idx [4];
  logic signed [63:0] prod;
  logic signed [65:0] acc_b, acc_m;

  // matrix RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;
  logic [8:0]    slot9;

  assign slot9 = {1'b0, item.data.load_slot};
  assign we    = item.valid && item.ready && (item.data.operation == lbsp_pkg::OP_LOAD)
                 && (slot9 <= NB9);
  assign waddr = {slot9[SW-1:0], item.data.element_slot};
  // bone element (row j, col i) read as blended (i,j); world read at (i,j)
  assign raddr = (state == W_RD) ? {WORLD_SLOT, i, j} : {idx[k], j, i};

  lbsp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(item.data.load_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign item.ready = (state == IDLE);

  // fourth weight
  logic signed [33:0] wsum;
  logic signed [34:0] w4;
  logic signed [65:0] w4_ext;
  assign wsum = 34'(item.data.weight_first) + 34'(item.data.weight_second)
              + 34'(item.data.weight_third);
  assign w4     = 35'(ONE) - 35'(wsum);
  assign w4_ext = 66'(w4) <<< FRAC_BITS;

  logic signed [65:0] sum_b, sum_m;
  assign sum_b = acc_b + 66'(prod);
  assign sum_m = acc_m + 66'(prod);

  logic [6:0] bf [4];
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      bf[n] = item.data.bone_indices[7*n +: 7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result.valid <= 1'b0;
      i <= '0;
      j <= '0;
      k <= '0;
    end else begin
      // OUT reloads the register itself when it is free
      if (result.valid && result.ready && state != OUT) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (item.valid && item.data.operation == lbsp_pkg::OP_SKIN) begin
            wgt[0] <= item.data.weight_first;
            wgt[1] <= item.data.weight_second;
            wgt[2] <= item.data.weight_third;
            wgt[3] <= sat_shift(w4_ext);
            vec[0] <= item.data.point_x;
            vec[1] <= item.data.point_y;
            vec[2] <= item.data.point_z;
            vec[3] <= ONE;
            for (int n = 0; n < 4; n++) begin
              if ({2'b00, bf[n]} >= NB9) idx[n] <= SW'(NB9 - 9'd1);
              else idx[n] <= SW'({2'b00, bf[n]});
            end
            acc_b <= '0;
            acc_m <= '0;
            i <= '0;
            j <= '0;
            k <= '0;
            state <= B_RD;
          end
        end
        B_RD: state <= B_MUL;
        B_MUL: begin
          prod  <= wgt[k] * $signed(rdata);
          state <= B_ACC;
        end
        B_ACC: begin
          acc_b <= sum_b;
          k     <= k + 2'd1;
          state <= (k == 2'd3) ? V_MUL : B_RD;
        end
        V_MUL: begin
          prod  <= vec[i] * sat_shift(acc_b);
          acc_b <= '0;
          state <= V_ACC;
        end
        V_ACC: begin
          i <= i + 2'd1;
          if (i == 2'd3) begin
            mid[j] <= sat_shift(sum_m);
            acc_m  <= '0;
            j      <= j + 2'd1;
            state  <= (j == 2'd3) ? W_RD : B_RD;
          end else begin
            acc_m <= sum_m;
            state <= B_RD;
          end
        end
        W_RD: state <= W_MUL;
        W_MUL: begin
          prod  <= mid[i] * $signed(rdata);
          state <= W_ACC;
        end
        W_ACC: begin
          i <= i + 2'd1;
          if (i == 2'd3) begin
            res[j] <= sat_shift(sum_m);
            acc_m  <= '0;
            j      <= j + 2'd1;
            state  <= (j == 2'd3) ? OUT : W_RD;
          end else begin
            acc_m <= sum_m;
            state <= W_RD;
          end
        end
        OUT: begin
          if (!result.valid || result.ready) begin
            result.data  <= '{res[0], res[1], res[2], res[3]};
            result.valid <= 1'b1;
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/lbsp_ram.sv =====
`default_nettype none
module lbsp_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 2064,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/lbsp_checker.sv =====
`default_nettype none
module lbsp_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           in_op,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire lbsp_pkg::out_t out_data
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // a skin transfer makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op == lbsp_pkg::OP_SKIN |=> !in_ready)
    else $error("skin item did not occupy the datapath");

  // no result right after any transfer
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  // a new result comes only from the busy datapath
  a_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");
endmodule

bind linear_blend_skinning_point lbsp_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (item.valid),
  .in_ready (item.ready),
  .in_op    (item.data.operation),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_data (result.data)
);
`default_nettype wire
